// File: src/twm_pkg.sv
// ----------------------------------------------------------------------------
// twm_pkg
// Shared types, register indexes and helper functions of the two-wire
// write/read master.
// ----------------------------------------------------------------------------
package twm_pkg;

  // Default width of the tick counter inside one delay unit.
  localparam int COUNT_WIDTH_DEFAULT = 16;

  // Field widths.
  localparam int TPU_WIDTH   = 16;
  localparam int UNIT_WIDTH  = 4;
  localparam int GAP_WIDTH   = 5;
  localparam int BYTE_WIDTH  = 8;
  localparam int BIT_CNT_W   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 16;

  // Byte that marks a good reply from the partner.
  localparam logic [BYTE_WIDTH-1:0] REPLY_MATCH = 8'h75;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS_PER_UNIT = 3'd0,
    CFG_LOW_UNITS      = 3'd1,
    CFG_HIGH_UNITS     = 3'd2,
    CFG_READ_UNITS     = 3'd3,
    CFG_GAP_UNITS      = 3'd4
  } cfg_index_t;

  // Reset values of the configuration registers.
  localparam logic [TPU_WIDTH-1:0]  TPU_RESET  = 16'd1000;
  localparam logic [UNIT_WIDTH-1:0] LOW_RESET  = 4'd3;
  localparam logic [UNIT_WIDTH-1:0] HIGH_RESET = 4'd5;
  localparam logic [UNIT_WIDTH-1:0] READ_RESET = 4'd5;
  localparam logic [GAP_WIDTH-1:0]  GAP_RESET  = 5'd10;

  typedef struct packed {
    logic [TPU_WIDTH-1:0]  ticks_per_unit;
    logic [UNIT_WIDTH-1:0] low_units;
    logic [UNIT_WIDTH-1:0] high_units;
    logic [UNIT_WIDTH-1:0] read_units;
    logic [GAP_WIDTH-1:0]  gap_units;
  } twm_cfg_t;

  typedef struct packed {
    logic                  reply_ok;
    logic [BYTE_WIDTH-1:0] read_byte;
    logic                  done_res;
    logic                  busy_res;
    logic                  sda_drive;
    logic                  sda_out;
    logic                  scl_out;
  } twm_result_t;

  // Transaction phases, one-hot.
  typedef enum logic [16:0] {
    PH_IDLE      = 17'h00001,
    PH_ST_A      = 17'h00002,
    PH_ST_B      = 17'h00004,
    PH_ST_C      = 17'h00008,
    PH_ST_D      = 17'h00010,
    PH_TX_SETUP  = 17'h00020,
    PH_TX_HIGH   = 17'h00040,
    PH_TX_LOW    = 17'h00080,
    PH_TX_GAP    = 17'h00100,
    PH_RX_HIGH   = 17'h00200,
    PH_RX_LOW    = 17'h00400,
    PH_ACK_SETUP = 17'h00800,
    PH_ACK_HIGH  = 17'h01000,
    PH_SP_A      = 17'h02000,
    PH_SP_B      = 17'h04000,
    PH_SP_C      = 17'h08000,
    PH_SP_D      = 17'h10000
  } phase_t;

  // A length of zero counts as one unit.
  function automatic logic [GAP_WIDTH-1:0] at_least_one(input logic [GAP_WIDTH-1:0] v);
    return (v == '0) ? GAP_WIDTH'(1) : v;
  endfunction

  // Number of delay units that the given phase lasts.
  function automatic logic [GAP_WIDTH-1:0] phase_units(input phase_t p, input twm_cfg_t c);
    logic [GAP_WIDTH-1:0] u;
    case (p)
      PH_ST_A, PH_ST_C, PH_TX_SETUP, PH_TX_LOW, PH_SP_A, PH_SP_C:
        u = at_least_one(GAP_WIDTH'(c.low_units));
      PH_ST_B, PH_ST_D, PH_TX_HIGH, PH_SP_B, PH_SP_D:
        u = at_least_one(GAP_WIDTH'(c.high_units));
      PH_TX_GAP:
        u = at_least_one(c.gap_units);
      default:
        u = at_least_one(GAP_WIDTH'(c.read_units));
    endcase
    return u;
  endfunction

endpackage

// File: src/twm_core.sv
// ----------------------------------------------------------------------------
// twm_core
// Phase sequencer, delay counters and line levels. One tick is applied on
// every cycle that step is high; the result shows the levels after it.
// ----------------------------------------------------------------------------
module twm_core #(
  parameter int COUNT_WIDTH = twm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  op,
  input  logic [7:0]            first_byte,
  input  logic [7:0]            second_byte,
  input  logic                  sda_in,
  input  twm_pkg::twm_cfg_t     cfg,
  output twm_pkg::twm_result_t  result
);
  import twm_pkg::*;

  localparam int LW = (COUNT_WIDTH > TPU_WIDTH) ? COUNT_WIDTH : TPU_WIDTH;
  localparam logic [LW-1:0] CNT_MAX = LW'({COUNT_WIDTH{1'b1}});

  phase_t                 phase, phase_next;
  logic [BIT_CNT_W-1:0]   bit_count, bit_count_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next, tick_inc, limit;
  logic [GAP_WIDTH-1:0]   unit_count, unit_count_next, unit_inc;
  logic [BYTE_WIDTH-1:0]  shift_reg, shift_reg_next;
  logic [BYTE_WIDTH-1:0]  held_second, held_second_next;
  logic [BYTE_WIDTH-1:0]  last_read, last_read_next;
  logic                   scl, scl_next, sda, sda_next, drv, drv_next;
  logic                   done, entering;
  logic [LW-1:0]          tpu_ext, limit_wide;

  // Unit length in ticks, at least one and capped at the counter range.
  always_comb begin
    tpu_ext    = LW'(cfg.ticks_per_unit);
    limit_wide = (tpu_ext == '0) ? LW'(1) : tpu_ext;
    if (limit_wide > CNT_MAX) begin
      limit_wide = CNT_MAX;
    end
    limit = limit_wide[COUNT_WIDTH-1:0];
  end

  assign tick_inc = tick_count + COUNT_WIDTH'(1);
  assign unit_inc = unit_count + GAP_WIDTH'(1);

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    tick_count_next  = tick_count;
    unit_count_next  = unit_count;
    shift_reg_next   = shift_reg;
    held_second_next = held_second;
    last_read_next   = last_read;
    scl_next         = scl;
    sda_next         = sda;
    drv_next         = drv;
    done             = 1'b0;
    entering         = 1'b0;

    if (phase == PH_IDLE) begin
      if (op) begin
        shift_reg_next   = first_byte;
        held_second_next = second_byte;
        bit_count_next   = '0;
        tick_count_next  = '0;
        unit_count_next  = '0;
        phase_next       = PH_ST_A;
        entering         = 1'b1;
      end
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= limit) begin
        tick_count_next = '0;
        unit_count_next = unit_inc;
        if (unit_inc >= phase_units(phase, cfg)) begin
          unit_count_next = '0;
          entering        = 1'b1;
          unique case (phase)
            PH_ST_A:     phase_next = PH_ST_B;
            PH_ST_B:     phase_next = PH_ST_C;
            PH_ST_C:     phase_next = PH_ST_D;
            PH_ST_D: begin
              bit_count_next = 4'd15;
              phase_next     = PH_TX_SETUP;
            end
            PH_TX_SETUP: phase_next = PH_TX_HIGH;
            PH_TX_HIGH:  phase_next = (bit_count[2:0] == 3'd0) ? PH_TX_GAP : PH_TX_LOW;
            PH_TX_LOW: begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              bit_count_next = bit_count - 4'd1;
              phase_next     = PH_TX_SETUP;
            end
            PH_TX_GAP: begin
              bit_count_next = 4'd7;
              if (bit_count[3]) begin
                shift_reg_next = held_second;
                phase_next     = PH_TX_SETUP;
              end else begin
                shift_reg_next = '0;
                phase_next     = PH_RX_HIGH;
              end
            end
            PH_RX_HIGH: begin
              shift_reg_next = {shift_reg[6:0], sda_in};
              phase_next     = PH_RX_LOW;
            end
            PH_RX_LOW: begin
              if (bit_count == '0) begin
                phase_next = PH_ACK_SETUP;
              end else begin
                bit_count_next = bit_count - 4'd1;
                phase_next     = PH_RX_HIGH;
              end
            end
            PH_ACK_SETUP: phase_next = PH_ACK_HIGH;
            PH_ACK_HIGH: begin
              last_read_next = shift_reg;
              phase_next     = PH_SP_A;
            end
            PH_SP_A:     phase_next = PH_SP_B;
            PH_SP_B:     phase_next = PH_SP_C;
            PH_SP_C:     phase_next = PH_SP_D;
            PH_SP_D: begin
              bit_count_next = '0;
              done           = 1'b1;
              phase_next     = PH_IDLE;
            end
            default:     phase_next = PH_IDLE;
          endcase
        end
      end
    end

    // Line levels set on entry to a phase.
    if (entering) begin
      unique case (phase_next)
        PH_ST_A: begin
          drv_next = 1'b1;
          sda_next = 1'b1;
        end
        PH_ST_B:     scl_next = 1'b1;
        PH_ST_C:     sda_next = 1'b0;
        PH_ST_D:     scl_next = 1'b0;
        PH_TX_SETUP: begin
          drv_next = 1'b1;
          scl_next = 1'b0;
          sda_next = shift_reg_next[7];
        end
        PH_TX_HIGH:  scl_next = 1'b1;
        PH_TX_LOW:   scl_next = 1'b0;
        PH_TX_GAP: begin
          scl_next = 1'b0;
          if (!bit_count_next[3]) begin
            drv_next = 1'b0;
            sda_next = 1'b1;
          end
        end
        PH_RX_HIGH: begin
          drv_next = 1'b0;
          sda_next = 1'b1;
          scl_next = 1'b1;
        end
        PH_RX_LOW:   scl_next = 1'b0;
        PH_ACK_SETUP: begin
          drv_next = 1'b1;
          sda_next = 1'b0;
          scl_next = 1'b0;
        end
        PH_ACK_HIGH: scl_next = 1'b1;
        PH_SP_A: begin
          drv_next = 1'b1;
          scl_next = 1'b0;
        end
        PH_SP_B:     sda_next = 1'b0;
        PH_SP_C:     scl_next = 1'b1;
        PH_SP_D:     sda_next = 1'b1;
        default: begin
          scl_next = 1'b1;
          sda_next = 1'b1;
          drv_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      tick_count  <= '0;
      unit_count  <= '0;
      shift_reg   <= '0;
      held_second <= '0;
      last_read   <= '0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      drv         <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      tick_count  <= tick_count_next;
      unit_count  <= unit_count_next;
      shift_reg   <= shift_reg_next;
      held_second <= held_second_next;
      last_read   <= last_read_next;
      scl         <= scl_next;
      sda         <= sda_next;
      drv         <= drv_next;
    end
  end

  // Levels and status after the tick.
  always_comb begin
    result.scl_out   = scl_next;
    result.sda_out   = drv_next ? sda_next : 1'b1;
    result.sda_drive = drv_next;
    result.busy_res  = (phase_next != PH_IDLE);
    result.done_res  = done;
    result.read_byte = last_read_next;
    result.reply_ok  = (last_read_next == REPLY_MATCH);
  end

endmodule

// File: src/two_wire_write_read_master.sv
// ----------------------------------------------------------------------------
// two_wire_write_read_master
// Tick-driven two-wire master that sends two bytes and reads one back.
// ----------------------------------------------------------------------------
// Every request on the input stream is one timing tick. A tick whose tuser
// bit is set while the block is idle starts a transaction: a start condition,
// the two bytes from tdata sent MSB first without acknowledge clocks, a gap
// with the data line released, eight read clocks that sample sda_in, a driven
// acknowledge of zero and a stop condition. Each tick yields exactly one
// result request that carries the line levels after that tick, the busy and
// done flags, the last byte read and whether it equals 0x75. The block takes
// one tick per clock cycle: the sequencer, both delay counters and the line
// levels advance together on each tick, and the result is captured in an
// output register as the tick is accepted. The input is stalled only while that
// output register is full and the downstream side is not ready. Phase lengths
// come from the configuration registers, which may be written at any time
// through the cfg port and take effect on the next tick.
// ----------------------------------------------------------------------------
module two_wire_write_read_master #(
  parameter int COUNT_WIDTH = twm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input ticks.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: first_byte[7:0], second_byte[15:8], sda_in[16], zero fill above.
  input  logic [twm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: op (1 starts a transaction when idle).
  input  logic                              s_axis_tuser,
  // Results.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
  // read_byte[12:5], reply_ok[13], zero fill above.
  output logic [twm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [twm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [twm_pkg::TPU_WIDTH-1:0]     cfg_data
);
  import twm_pkg::*;

  twm_cfg_t    cfg;
  twm_result_t result;
  logic        step;
  logic        out_full;

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_unit <= TPU_RESET;
      cfg.low_units      <= LOW_RESET;
      cfg.high_units     <= HIGH_RESET;
      cfg.read_units     <= READ_RESET;
      cfg.gap_units      <= GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TICKS_PER_UNIT: cfg.ticks_per_unit <= cfg_data;
        CFG_LOW_UNITS:      cfg.low_units      <= cfg_data[UNIT_WIDTH-1:0];
        CFG_HIGH_UNITS:     cfg.high_units     <= cfg_data[UNIT_WIDTH-1:0];
        CFG_READ_UNITS:     cfg.read_units     <= cfg_data[UNIT_WIDTH-1:0];
        CFG_GAP_UNITS:      cfg.gap_units      <= cfg_data[GAP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // A new tick is taken whenever the output register is empty or drains now.
  assign s_axis_tready = !out_full || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  twm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .op          (s_axis_tuser),
    .first_byte  (s_axis_tdata[7:0]),
    .second_byte (s_axis_tdata[15:8]),
    .sda_in      (s_axis_tdata[16]),
    .cfg         (cfg),
    .result      (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (step) begin
      out_full <= 1'b1;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= OUT_DATA_W'(result);
    end
  end

  assign m_axis_tvalid = out_full;

endmodule

// File: tb/sv/twm_line_checker.sv
// ----------------------------------------------------------------------------
// twm_line_checker
// Watches the tick, result and register channels of the two-wire master,
// predicts the full result of every tick and compares each result with it.
// ----------------------------------------------------------------------------
module twm_line_checker
  import twm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TPU_WIDTH-1:0]  cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    finished,
  output int                    replies_ok
);
  timeunit 1ns;
  timeprecision 1ps;

  // Private copy of the registers and of the sequencer.
  twm_cfg_t              regs;
  phase_t                ph;
  logic [BIT_CNT_W-1:0]  bits_left;
  logic [TPU_WIDTH-1:0]  tick_cnt;
  logic [GAP_WIDTH-1:0]  unit_cnt;
  logic [BYTE_WIDTH-1:0] shifter;
  logic [BYTE_WIDTH-1:0] second_hold;
  logic [BYTE_WIDTH-1:0] last_rx;
  logic                  lv_scl;
  logic                  lv_sda;
  logic                  lv_drv;

  twm_result_t expected_levels[$];

  wire tick_req = s_axis_tvalid && s_axis_tready;
  wire res_req  = m_axis_tvalid && m_axis_tready;
  wire reg_req  = cfg_valid && cfg_ready;

  function automatic logic [GAP_WIDTH-1:0] units_for(input phase_t p);
    logic [GAP_WIDTH-1:0] n;
    case (p)
      PH_ST_A, PH_ST_C, PH_TX_SETUP, PH_TX_LOW, PH_SP_A, PH_SP_C:
        n = GAP_WIDTH'(regs.low_units);
      PH_ST_B, PH_ST_D, PH_TX_HIGH, PH_SP_B, PH_SP_D:
        n = GAP_WIDTH'(regs.high_units);
      PH_TX_GAP:
        n = regs.gap_units;
      default:
        n = GAP_WIDTH'(regs.read_units);
    endcase
    if (n == '0) n = GAP_WIDTH'(1);
    return n;
  endfunction

  // Entering a phase sets the line levels that it holds.
  function automatic void go_to(input phase_t p);
    ph = p;
    case (p)
      PH_ST_A:      begin lv_drv = 1'b1; lv_sda = 1'b1; end
      PH_ST_B:      lv_scl = 1'b1;
      PH_ST_C:      lv_sda = 1'b0;
      PH_ST_D:      lv_scl = 1'b0;
      PH_TX_SETUP:  begin lv_drv = 1'b1; lv_scl = 1'b0; lv_sda = shifter[BYTE_WIDTH-1]; end
      PH_TX_HIGH:   lv_scl = 1'b1;
      PH_TX_LOW:    lv_scl = 1'b0;
      PH_TX_GAP: begin
        lv_scl = 1'b0;
        if (bits_left < BIT_CNT_W'(8)) begin
          lv_drv = 1'b0;
          lv_sda = 1'b1;
        end
      end
      PH_RX_HIGH:   begin lv_drv = 1'b0; lv_sda = 1'b1; lv_scl = 1'b1; end
      PH_RX_LOW:    lv_scl = 1'b0;
      PH_ACK_SETUP: begin lv_drv = 1'b1; lv_sda = 1'b0; lv_scl = 1'b0; end
      PH_ACK_HIGH:  lv_scl = 1'b1;
      PH_SP_A:      begin lv_drv = 1'b1; lv_scl = 1'b0; end
      PH_SP_B:      lv_sda = 1'b0;
      PH_SP_C:      lv_scl = 1'b1;
      PH_SP_D:      lv_sda = 1'b1;
      default:      begin lv_scl = 1'b1; lv_sda = 1'b1; lv_drv = 1'b0; end
    endcase
  endfunction

  // Leaves the current phase; returns 1 when the stop condition completes.
  function automatic logic end_phase(input logic sda);
    logic fin;
    fin = 1'b0;
    case (ph)
      PH_ST_A: go_to(PH_ST_B);
      PH_ST_B: go_to(PH_ST_C);
      PH_ST_C: go_to(PH_ST_D);
      PH_ST_D: begin
        bits_left = BIT_CNT_W'(15);
        go_to(PH_TX_SETUP);
      end
      PH_TX_SETUP: go_to(PH_TX_HIGH);
      PH_TX_HIGH: begin
        if (bits_left[2:0] == 3'd0) go_to(PH_TX_GAP);
        else go_to(PH_TX_LOW);
      end
      PH_TX_LOW: begin
        shifter   = shifter << 1;
        bits_left = bits_left - BIT_CNT_W'(1);
        go_to(PH_TX_SETUP);
      end
      PH_TX_GAP: begin
        bits_left = BIT_CNT_W'(7);
        if (ph == PH_TX_GAP && !lv_drv) begin
          shifter = '0;
          go_to(PH_RX_HIGH);
        end else begin
          shifter = second_hold;
          go_to(PH_TX_SETUP);
        end
      end
      PH_RX_HIGH: begin
        shifter = {shifter[BYTE_WIDTH-2:0], sda};
        go_to(PH_RX_LOW);
      end
      PH_RX_LOW: begin
        if (bits_left == '0) begin
          go_to(PH_ACK_SETUP);
        end else begin
          bits_left = bits_left - BIT_CNT_W'(1);
          go_to(PH_RX_HIGH);
        end
      end
      PH_ACK_SETUP: go_to(PH_ACK_HIGH);
      PH_ACK_HIGH: begin
        last_rx = shifter;
        go_to(PH_SP_A);
      end
      PH_SP_A: go_to(PH_SP_B);
      PH_SP_B: go_to(PH_SP_C);
      PH_SP_C: go_to(PH_SP_D);
      PH_SP_D: begin
        bits_left = '0;
        go_to(PH_IDLE);
        fin = 1'b1;
      end
      default: go_to(PH_IDLE);
    endcase
    return fin;
  endfunction

  function automatic twm_result_t predict_tick(input logic op, input logic [BYTE_WIDTH-1:0] b1,
                                               input logic [BYTE_WIDTH-1:0] b2, input logic sda);
    twm_result_t r;
    logic [TPU_WIDTH-1:0] unit_len;
    logic fin;
    fin = 1'b0;
    if (ph == PH_IDLE) begin
      if (op) begin
        shifter     = b1;
        second_hold = b2;
        bits_left   = '0;
        tick_cnt    = '0;
        unit_cnt    = '0;
        go_to(PH_ST_A);
      end
    end else begin
      unit_len = (regs.ticks_per_unit == '0) ? TPU_WIDTH'(1) : regs.ticks_per_unit;
      tick_cnt = tick_cnt + TPU_WIDTH'(1);
      // A shortened length takes effect at once: a count already past it ends the unit.
      if (tick_cnt >= unit_len) begin
        tick_cnt = '0;
        unit_cnt = unit_cnt + GAP_WIDTH'(1);
        if (unit_cnt >= units_for(ph)) begin
          unit_cnt = '0;
          fin = end_phase(sda);
        end
      end
    end
    r.scl_out   = lv_scl;
    r.sda_out   = lv_drv ? lv_sda : 1'b1;
    r.sda_drive = lv_drv;
    r.busy_res  = (ph != PH_IDLE);
    r.done_res  = fin;
    r.read_byte = last_rx;
    r.reply_ok  = (last_rx == REPLY_MATCH);
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  always_ff @(posedge clk) begin
    if (rst) outstanding <= 0;
    else outstanding <= outstanding + int'(tick_req) - int'(res_req);
  end

  always @(posedge clk) begin : watch
    twm_result_t want;
    twm_result_t got;
    if (rst) begin
      regs.ticks_per_unit = TPU_RESET;
      regs.low_units      = LOW_RESET;
      regs.high_units     = HIGH_RESET;
      regs.read_units     = READ_RESET;
      regs.gap_units      = GAP_RESET;
      ph          = PH_IDLE;
      bits_left   = '0;
      tick_cnt    = '0;
      unit_cnt    = '0;
      shifter     = '0;
      second_hold = '0;
      last_rx     = '0;
      lv_scl      = 1'b1;
      lv_sda      = 1'b1;
      lv_drv      = 1'b0;
      expected_levels.delete();
      mismatches = 0;
      finished   = 0;
      replies_ok = 0;
    end else begin
      // The result of a tick accepted now can only leave later, so pop first.
      if (res_req) begin
        got = twm_result_t'(m_axis_tdata[$bits(twm_result_t)-1:0]);
        if (expected_levels.size() == 0) begin
          $error("result request with no tick waiting for it");
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          check_field("scl_out",   want.scl_out,   got.scl_out);
          check_field("sda_out",   want.sda_out,   got.sda_out);
          check_field("sda_drive", want.sda_drive, got.sda_drive);
          check_field("busy_res",  want.busy_res,  got.busy_res);
          check_field("done_res",  want.done_res,  got.done_res);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("reply_ok",  want.reply_ok,  got.reply_ok);
          if (got.done_res) finished++;
          if (got.done_res && got.reply_ok) replies_ok++;
        end
      end
      if (tick_req) begin
        expected_levels.push_back(predict_tick(s_axis_tuser, s_axis_tdata[7:0],
                                               s_axis_tdata[15:8], s_axis_tdata[16]));
      end
      // A register write counts from the next tick on.
      if (reg_req) begin
        case (cfg_index)
          CFG_TICKS_PER_UNIT: regs.ticks_per_unit = cfg_data;
          CFG_LOW_UNITS:      regs.low_units      = cfg_data[UNIT_WIDTH-1:0];
          CFG_HIGH_UNITS:     regs.high_units     = cfg_data[UNIT_WIDTH-1:0];
          CFG_READ_UNITS:     regs.read_units     = cfg_data[UNIT_WIDTH-1:0];
          CFG_GAP_UNITS:      regs.gap_units      = cfg_data[GAP_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/sv/tb_two_wire_write_read_master.sv
// ----------------------------------------------------------------------------
// tb_two_wire_write_read_master
// Drives timing ticks and register writes into the two-wire master and
// reports the verdict; a separate line checker predicts every result.
// ----------------------------------------------------------------------------
module tb_two_wire_write_read_master;
  timeunit 1ns;
  timeprecision 1ps;
  import twm_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 8;
  localparam int MAX_WAIT       = 19;
  // Long receiver hold-off that fills the output register and stalls the ticks.
  localparam int LONG_HOLD      = 300;
  // Cycles without any accepted request before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 8;
  localparam int TOTAL_TICKS    = 1420;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [TPU_WIDTH-1:0]  cfg_data = '0;

  int mismatches;
  int outstanding;
  int finished;
  int replies_ok;

  int ticks_sent = 0;
  int reg_writes = 0;
  int idle_cycles;
  // Shared with the result sink: no_idle removes all random waits for a
  // phase, hold_request asks the sink for one long hold-off.
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;

  // What the stimulus has learned from the results seen so far. It is used
  // to time starts and to steer sda_in so read bytes hit the reply byte at times.
  logic                  seen_busy;
  logic                  seen_scl;
  logic                  seen_drv;
  int                    rx_falls;
  logic [BYTE_WIDTH-1:0] reply_target;
  logic                  noisy_reply;
  twm_result_t           seen;

  always #(CLK_HALF) clk = ~clk;

  two_wire_write_read_master i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  twm_line_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .finished      (finished),
    .replies_ok    (replies_ok)
  );

  assign seen = twm_result_t'(m_axis_tdata[$bits(twm_result_t)-1:0]);

  // Follow the read clocks on the result stream. A falling clock edge with
  // the data line released ends one read bit, so the next tick should carry
  // the next bit of the chosen reply. Every finished transaction picks a new
  // reply: mostly the matching byte, sometimes one bit off, sometimes random,
  // and now and then pure noise on sda_in.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_busy    <= 1'b0;
      seen_scl     <= 1'b1;
      seen_drv     <= 1'b0;
      rx_falls     <= 0;
      reply_target <= REPLY_MATCH;
      noisy_reply  <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (!seen.busy_res) begin
        rx_falls <= 0;
        if (seen_busy) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: reply_target <= REPLY_MATCH;
            5, 6:          reply_target <= REPLY_MATCH ^ (8'h01 << $urandom_range(0, 7));
            default:       reply_target <= 8'($urandom_range(0, 255));
          endcase
          noisy_reply <= ($urandom_range(0, 9) == 0);
        end
      end else if (seen_scl && !seen_drv && !seen.scl_out) begin
        rx_falls <= rx_falls + 1;
      end
      seen_busy <= seen.busy_res;
      seen_scl  <= seen.scl_out;
      seen_drv  <= seen.sda_drive;
    end
  end

  // The run is hung once no request of any channel has gone through for a
  // long time; the longest legal quiet stretch is the receiver hold-off.
  always_ff @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("two_wire_write_read_master test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink. Before each result it waits a random number of cycles with
  // tready low; on request it holds off for a long stretch instead, while the
  // tick sender keeps offering, so the block fills up and stalls its input.
  initial begin : result_sink
    int hold;
    forever begin
      if (hold_request) begin
        hold = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // One register write request; the caller lowers cfg_valid after a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TPU_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One tick request, after a random wait with tvalid low.
  task automatic send_tick(input logic op, input logic [BYTE_WIDTH-1:0] b1,
                           input logic [BYTE_WIDTH-1:0] b2, input logic sda);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'({sda, b2, b1});
    do @(posedge clk); while (!s_axis_tready);
    ticks_sent++;
  endtask

  // Stop offering ticks and wait until every result has come out. Registers
  // are written only after this, so the block is quiet on the stream side.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding > 0) @(posedge clk);
  endtask

  // Random register value: mostly short lengths so that transactions finish
  // within a phase, sometimes zero (counts as one), sometimes long ones.
  // Bits above the register width are filled at random; the block drops them.
  function automatic logic [TPU_WIDTH-1:0] draw_units(input int width, input int top);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 5) v = 1;
    else if (r < 8) v = $urandom_range(2, 3);
    else if (r == 8) v = 0;
    else v = $urandom_range(4, top);
    return (TPU_WIDTH'($urandom_range(0, 65535)) << width) | TPU_WIDTH'(v);
  endfunction

  initial begin : stimulus
    int r;
    int n;
    int phase_no;
    logic op;
    logic sda;
    logic [TPU_WIDTH-1:0] tpu;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part. With the reset lengths one delay unit is 1000 ticks,
    // so the transaction started here is still in its start condition when
    // the registers first change below; each change therefore hits a
    // transaction in flight.
    send_tick(1'b0, 8'h00, 8'h00, 1'b1);   // plain tick while idle: reset levels
    send_tick(1'b1, 8'hFF, 8'h00, 1'b0);   // start with extreme bytes
    send_tick(1'b1, 8'h00, 8'hFF, 1'b1);   // start while busy is ignored
    send_tick(1'b0, 8'hFF, 8'hFF, 1'b0);
    settle();

    // Longest lengths everywhere.
    write_reg(CFG_TICKS_PER_UNIT, 16'hFFFF);
    write_reg(CFG_LOW_UNITS, 16'd15);
    write_reg(CFG_HIGH_UNITS, 16'd15);
    write_reg(CFG_READ_UNITS, 16'd15);
    write_reg(CFG_GAP_UNITS, 16'd31);
    end_writes();
    repeat (5) send_tick(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
    settle();

    // Zero lengths act as one, and the tick count already past the new
    // unit length ends the unit on the very next tick.
    write_reg(CFG_TICKS_PER_UNIT, 16'd0);
    write_reg(CFG_LOW_UNITS, 16'd0);
    write_reg(CFG_HIGH_UNITS, 16'd0);
    write_reg(CFG_READ_UNITS, 16'd0);
    write_reg(CFG_GAP_UNITS, 16'd0);
    end_writes();
    repeat (8) send_tick(1'b0, 8'h00, 8'hFF, 1'b0);
    settle();

    // All data bits set: the unit registers keep only their low bits, and a
    // write to an unused index changes nothing.
    write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), 16'hFFFF);
    write_reg(CFG_LOW_UNITS, 16'hFFFF);
    write_reg(CFG_HIGH_UNITS, 16'hFFFF);
    write_reg(CFG_READ_UNITS, 16'hFFFF);
    write_reg(CFG_GAP_UNITS, 16'hFFFF);
    write_reg(CFG_TICKS_PER_UNIT, 16'd1);
    end_writes();
    repeat (6) send_tick(1'b0, 8'hFF, 8'h00, 1'b1);

    // Random part in phases. Each phase starts from a quiet stream, rewrites
    // some registers (possibly in the middle of a transaction) and then sends
    // a burst of ticks. Starts are issued mostly while the results say idle.
    phase_no = 0;
    while (ticks_sent < TOTAL_TICKS) begin
      settle();
      if (phase_no == 0 || $urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 9);
        if (r < 6) tpu = 16'd1;
        else if (r < 8) tpu = TPU_WIDTH'($urandom_range(2, 4));
        else if (r == 8) tpu = 16'd0;
        else tpu = TPU_WIDTH'($urandom_range(5, 40));
        write_reg(CFG_TICKS_PER_UNIT, tpu);
      end
      if (phase_no == 0 || $urandom_range(0, 1) == 0)
        write_reg(CFG_LOW_UNITS, draw_units(UNIT_WIDTH, 15));
      if (phase_no == 0 || $urandom_range(0, 1) == 0)
        write_reg(CFG_HIGH_UNITS, draw_units(UNIT_WIDTH, 15));
      if (phase_no == 0 || $urandom_range(0, 1) == 0)
        write_reg(CFG_READ_UNITS, draw_units(UNIT_WIDTH, 15));
      if (phase_no == 0 || $urandom_range(0, 1) == 0)
        write_reg(CFG_GAP_UNITS, draw_units(GAP_WIDTH, 31));
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                  16'($urandom_range(0, 65535)));
      end_writes();

      no_idle = ($urandom_range(0, 4) == 0);
      if (phase_no == 2) begin
        no_idle = 1'b0;
        hold_request = 1'b1;
      end

      n = $urandom_range(60, 250);
      if (n > TOTAL_TICKS - ticks_sent) n = TOTAL_TICKS - ticks_sent;
      repeat (n) begin
        op = seen_busy ? ($urandom_range(0, 49) == 0) : ($urandom_range(0, 2) == 0);
        if (noisy_reply) sda = 1'($urandom_range(0, 1));
        else sda = reply_target[(rx_falls > 7) ? 0 : 7 - rx_falls];
        send_tick(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sda);
      end
      phase_no++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d ticks in %0d phases with %0d register writes; %0d transactions ended.",
             ticks_sent, phase_no, reg_writes, finished);
    $display("%0d of them read back the reply byte; %0d field mismatches.",
             replies_ok, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("two_wire_write_read_master test passed");
    end else begin
      $display("two_wire_write_read_master test failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/twm_pkg.sv
src/twm_core.sv
src/two_wire_write_read_master.sv
tb/sv/twm_line_checker.sv
tb/sv/tb_two_wire_write_read_master.sv
